// File: hw/rtl/tbr_pkg.sv
`default_nettype none

package tbr_pkg;

  // Default build sizes
  localparam int MAX_DIM_DEF    = 4096;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int PIX_W      = 12;
  localparam int VP_POS_W   = 13;
  localparam int VP_SIZE_W  = 14;
  localparam int FB_SIZE_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int VTX_IDX_W  = 2;

  // Vertex slot that completes a triangle
  localparam logic [VTX_IDX_W-1:0] VTX_LAST = 2'd2;

  // Framebuffer size after reset
  localparam logic [FB_SIZE_W-1:0] FB_SIZE_RESET = 13'd1;

  // Opcodes of an input item
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEWPORT_X    = 3'd0,
    CFG_VIEWPORT_Y    = 3'd1,
    CFG_VIEWPORT_W    = 3'd2,
    CFG_VIEWPORT_H    = 3'd3,
    CFG_FRAME_WIDTH   = 3'd4,
    CFG_FRAME_HEIGHT  = 3'd5
  } cfg_idx_e;

  // Triangle setup status towards the scan logic
  typedef struct packed {
    logic busy;
    logic done;
    logic empty;
  } su_status_t;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             covered;
    logic             in_scan;
    logic             last_pixel;
  } res_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbr_setup.sv
`default_nettype none

// Triangle setup: holds the three vertices, clamps the bounding box and
// works out the edge deltas, doubled area and edge values at the box corner.
// Stages: box clamp -> corner offsets -> products -> sums (read by the scan).
module tbr_setup #(
  parameter int MAX_DIM    = tbr_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF,
  localparam int PW = $clog2(MAX_DIM),
  localparam int DW = tbr_pkg::max_int(COORD_BITS, PW + 1) + 1,
  localparam int UW = 2 * DW + 1
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic signed [tbr_pkg::VP_POS_W-1:0]  vp_x_i,
  input  wire logic signed [tbr_pkg::VP_POS_W-1:0]  vp_y_i,
  input  wire logic [tbr_pkg::VP_SIZE_W-1:0]        vp_w_i,
  input  wire logic [tbr_pkg::VP_SIZE_W-1:0]        vp_h_i,
  input  wire logic [tbr_pkg::FB_SIZE_W-1:0]        fb_w_i,
  input  wire logic [tbr_pkg::FB_SIZE_W-1:0]        fb_h_i,
  // vertex write, start with the last vertex
  input  wire logic                                 vtx_we_i,
  input  wire logic [tbr_pkg::VTX_IDX_W-1:0]        vtx_idx_i,
  input  wire logic signed [COORD_BITS-1:0]         vtx_x_i,
  input  wire logic signed [COORD_BITS-1:0]         vtx_y_i,
  input  wire logic                                 start_i,
  // results
  output tbr_pkg::su_status_t                       status_o,
  output logic [PW-1:0]                             min_x_o,
  output logic [PW-1:0]                             min_y_o,
  output logic [PW-1:0]                             max_x_o,
  output logic [PW-1:0]                             max_y_o,
  output logic signed [DW-1:0]                      e1x_o,
  output logic signed [DW-1:0]                      e1y_o,
  output logic signed [DW-1:0]                      e2x_o,
  output logic signed [DW-1:0]                      e2y_o,
  output logic signed [UW-1:0]                      area_o,
  output logic signed [UW-1:0]                      u0_o,
  output logic signed [UW-1:0]                      v0_o
);

  localparam int CW = tbr_pkg::max_int(tbr_pkg::max_int(COORD_BITS, PW + 2), 16) + 1;
  localparam int PRW = 2 * DW;

  localparam logic [2:0] SU_IDLE = 3'd0;
  localparam logic [2:0] SU_BOX  = 3'd1;
  localparam logic [2:0] SU_DIFF = 3'd2;
  localparam logic [2:0] SU_MUL  = 3'd3;
  localparam logic [2:0] SU_SUM  = 3'd4;

  logic [2:0] su_q, su_d;

  logic signed [COORD_BITS-1:0] vx_q [3];
  logic signed [COORD_BITS-1:0] vy_q [3];

  logic empty_q;
  logic [PW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [DW-1:0] e1x_q, e1y_q, e2x_q, e2y_q, dpx_q, dpy_q;
  logic signed [PRW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;

  // clamp datapath
  logic signed [CW-1:0] x0, x1, x2, y0, y1, y2;
  logic signed [CW-1:0] mn_x01, mn_y01, mx_x01, mx_y01;
  logic signed [CW-1:0] mn_x, mn_y, mx_x, mx_y;
  logic signed [CW-1:0] vpx, vpy, vpw, vph, fw_e, fh_e, fw_c, fh_c;
  logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y, hv_x, hv_y, hf_x, hf_y;
  logic signed [CW-1:0] bmn_x, bmn_y, bmx_x, bmx_y;
  logic signed [CW-1:0] cmn_x, cmn_y, cmx_x, cmx_y;
  logic box_empty;

  // Sequencer
  always_comb begin
    case (su_q)
      SU_IDLE: su_d = start_i ? SU_BOX : SU_IDLE;
      SU_BOX:  su_d = SU_DIFF;
      SU_DIFF: su_d = SU_MUL;
      SU_MUL:  su_d = SU_SUM;
      SU_SUM:  su_d = SU_IDLE;
      default: su_d = SU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_q    <= SU_IDLE;
      empty_q <= 1'b0;
    end else begin
      su_q <= su_d;
      if (su_q == SU_BOX) begin
        empty_q <= box_empty;
      end
    end
  end

  // Vertex store
  always_ff @(posedge clk_i) begin
    if (vtx_we_i) begin
      vx_q[vtx_idx_i] <= vtx_x_i;
      vy_q[vtx_idx_i] <= vtx_y_i;
    end
  end

  // Vertex extremes
  always_comb begin
    x0 = CW'(vx_q[0]);
    x1 = CW'(vx_q[1]);
    x2 = CW'(vx_q[2]);
    y0 = CW'(vy_q[0]);
    y1 = CW'(vy_q[1]);
    y2 = CW'(vy_q[2]);
    mn_x01 = (x1 < x0) ? x1 : x0;
    mx_x01 = (x1 > x0) ? x1 : x0;
    mn_y01 = (y1 < y0) ? y1 : y0;
    mx_y01 = (y1 > y0) ? y1 : y0;
    mn_x = (x2 < mn_x01) ? x2 : mn_x01;
    mx_x = (x2 > mx_x01) ? x2 : mx_x01;
    mn_y = (y2 < mn_y01) ? y2 : mn_y01;
    mx_y = (y2 > mx_y01) ? y2 : mx_y01;
  end

  // Clip window: viewport intersected with the framebuffer
  always_comb begin
    vpx  = CW'(vp_x_i);
    vpy  = CW'(vp_y_i);
    vpw  = CW'($signed({1'b0, vp_w_i}));
    vph  = CW'($signed({1'b0, vp_h_i}));
    fw_e = CW'($signed({1'b0, fb_w_i}));
    fh_e = CW'($signed({1'b0, fb_h_i}));
    fw_c = (fw_e > CW'(MAX_DIM)) ? CW'(MAX_DIM) : fw_e;
    fh_c = (fh_e > CW'(MAX_DIM)) ? CW'(MAX_DIM) : fh_e;
    lo_x = vpx[CW-1] ? '0 : vpx;
    lo_y = vpy[CW-1] ? '0 : vpy;
    hv_x = vpx + vpw - CW'(1);
    hv_y = vpy + vph - CW'(1);
    hf_x = fw_c - CW'(1);
    hf_y = fh_c - CW'(1);
    hi_x = (hf_x < hv_x) ? hf_x : hv_x;
    hi_y = (hf_y < hv_y) ? hf_y : hv_y;
    box_empty = (lo_x > hi_x) || (lo_y > hi_y);
  end

  // Clamp the vertex box into the window
  always_comb begin
    cmn_x = (mn_x < lo_x) ? lo_x : mn_x;
    cmn_y = (mn_y < lo_y) ? lo_y : mn_y;
    cmx_x = (mx_x < lo_x) ? lo_x : mx_x;
    cmx_y = (mx_y < lo_y) ? lo_y : mx_y;
    bmn_x = (cmn_x > hi_x) ? hi_x : cmn_x;
    bmn_y = (cmn_y > hi_y) ? hi_y : cmn_y;
    bmx_x = (cmx_x > hi_x) ? hi_x : cmx_x;
    bmx_y = (cmx_y > hi_y) ? hi_y : cmx_y;
  end

  // Box, edge deltas, corner offsets and products
  always_ff @(posedge clk_i) begin
    if (su_q == SU_BOX) begin
      min_x_q <= PW'(bmn_x);
      min_y_q <= PW'(bmn_y);
      max_x_q <= PW'(bmx_x);
      max_y_q <= PW'(bmx_y);
      e1x_q   <= DW'(vx_q[1]) - DW'(vx_q[0]);
      e1y_q   <= DW'(vy_q[1]) - DW'(vy_q[0]);
      e2x_q   <= DW'(vx_q[2]) - DW'(vx_q[0]);
      e2y_q   <= DW'(vy_q[2]) - DW'(vy_q[0]);
    end
    if (su_q == SU_DIFF) begin
      dpx_q <= DW'(vx_q[0]) - DW'($signed({1'b0, min_x_q}));
      dpy_q <= DW'(vy_q[0]) - DW'($signed({1'b0, min_y_q}));
    end
    if (su_q == SU_MUL) begin
      pa_q <= e1x_q * e2y_q;
      pb_q <= e2x_q * e1y_q;
      pc_q <= e2x_q * dpy_q;
      pd_q <= dpx_q * e2y_q;
      pe_q <= dpx_q * e1y_q;
      pf_q <= e1x_q * dpy_q;
    end
  end

  // Sums, taken by the scan logic while done is high
  assign area_o = UW'(pa_q) - UW'(pb_q);
  assign u0_o   = UW'(pc_q) - UW'(pd_q);
  assign v0_o   = UW'(pe_q) - UW'(pf_q);

  assign min_x_o = min_x_q;
  assign min_y_o = min_y_q;
  assign max_x_o = max_x_q;
  assign max_y_o = max_y_q;
  assign e1x_o   = e1x_q;
  assign e1y_o   = e1y_q;
  assign e2x_o   = e2x_q;
  assign e2y_o   = e2y_q;

  assign status_o.busy  = (su_q != SU_IDLE);
  assign status_o.done  = (su_q == SU_SUM);
  assign status_o.empty = empty_q;

endmodule

`default_nettype wire

// File: hw/rtl/triangle_bbox_edge_rasterizer.sv
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    opcode_i, vert_x_i, vert_y_i
// out       source     out_valid_o / out_stall_i  pixel_x_o, pixel_y_o, covered_o,
//                                                 in_scan_o, last_pixel_o
// cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per clock while in_stall_o is low: each step produces its pixel from the
// incrementally updated edge values (one add and compare for coverage).
// The vertex that completes a triangle holds in_stall_o high through the setup
// steps: box clamp, corner offsets, edge products, sums.
// Asynchronous active-low reset; configuration is always ready.
// Results pass an output register and one skid entry; a full skid stalls input.
`default_nettype none

module triangle_bbox_edge_rasterizer #(
  parameter int MAX_DIM    = tbr_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                opcode_i,
  input  wire logic signed [COORD_BITS-1:0]        vert_x_i,
  input  wire logic signed [COORD_BITS-1:0]        vert_y_i,
  // result items
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [tbr_pkg::PIX_W-1:0]                pixel_x_o,
  output logic [tbr_pkg::PIX_W-1:0]                pixel_y_o,
  output logic                                     covered_o,
  output logic                                     in_scan_o,
  output logic                                     last_pixel_o,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tbr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [tbr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int DW = tbr_pkg::max_int(COORD_BITS, PW + 1) + 1;
  localparam int UW = 2 * DW + 1;

  // configuration registers
  logic signed [tbr_pkg::VP_POS_W-1:0] vp_x_q, vp_y_q;
  logic [tbr_pkg::VP_SIZE_W-1:0]       vp_w_q, vp_h_q;
  logic [tbr_pkg::FB_SIZE_W-1:0]       fb_w_q, fb_h_q;

  // scan state
  logic                          scan_active_q;
  logic [tbr_pkg::VTX_IDX_W-1:0] vcnt_q;
  logic [PW-1:0]                 scan_x_q, scan_y_q;
  logic signed [UW-1:0]          u_q, v_q, urow_q, vrow_q, area_q;

  // setup results
  tbr_pkg::su_status_t  su_status;
  logic [PW-1:0]        min_x, min_y, max_x, max_y;
  logic signed [DW-1:0] e1x, e1y, e2x, e2y;
  logic signed [UW-1:0] area0, u0, v0;

  // handshake
  logic in_xfer, vtx_xfer, step_xfer, vtx_we, su_start;
  logic out_valid_q, skid_valid_q, out_take;
  tbr_pkg::res_t out_q, skid_q, res;

  // coverage
  logic signed [UW:0] sum_uv, area_x;
  logic area_pos, area_neg, u_neg, v_neg, u_le0, v_le0, cov;
  logic end_x, end_y;

  assign in_stall_o = skid_valid_q || su_status.busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign vtx_xfer   = in_xfer && (opcode_i == tbr_pkg::OP_VERTEX);
  assign step_xfer  = in_xfer && (opcode_i == tbr_pkg::OP_STEP);
  assign vtx_we     = vtx_xfer && !scan_active_q;
  assign su_start   = vtx_we && (vcnt_q == tbr_pkg::VTX_LAST);

  // Configuration register file; unknown indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q <= '0;
      vp_y_q <= '0;
      vp_w_q <= '0;
      vp_h_q <= '0;
      fb_w_q <= tbr_pkg::FB_SIZE_RESET;
      fb_h_q <= tbr_pkg::FB_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tbr_pkg::cfg_idx_e'(cfg_index_i))
        tbr_pkg::CFG_VIEWPORT_X:   vp_x_q <= $signed(cfg_data_i[tbr_pkg::VP_POS_W-1:0]);
        tbr_pkg::CFG_VIEWPORT_Y:   vp_y_q <= $signed(cfg_data_i[tbr_pkg::VP_POS_W-1:0]);
        tbr_pkg::CFG_VIEWPORT_W:   vp_w_q <= cfg_data_i[tbr_pkg::VP_SIZE_W-1:0];
        tbr_pkg::CFG_VIEWPORT_H:   vp_h_q <= cfg_data_i[tbr_pkg::VP_SIZE_W-1:0];
        tbr_pkg::CFG_FRAME_WIDTH:  fb_w_q <= cfg_data_i[tbr_pkg::FB_SIZE_W-1:0];
        tbr_pkg::CFG_FRAME_HEIGHT: fb_h_q <= cfg_data_i[tbr_pkg::FB_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Triangle setup
  tbr_setup #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vp_x_i    (vp_x_q),
    .vp_y_i    (vp_y_q),
    .vp_w_i    (vp_w_q),
    .vp_h_i    (vp_h_q),
    .fb_w_i    (fb_w_q),
    .fb_h_i    (fb_h_q),
    .vtx_we_i  (vtx_we),
    .vtx_idx_i (vcnt_q),
    .vtx_x_i   (vert_x_i),
    .vtx_y_i   (vert_y_i),
    .start_i   (su_start),
    .status_o  (su_status),
    .min_x_o   (min_x),
    .min_y_o   (min_y),
    .max_x_o   (max_x),
    .max_y_o   (max_y),
    .e1x_o     (e1x),
    .e1y_o     (e1y),
    .e2x_o     (e2x),
    .e2y_o     (e2y),
    .area_o    (area0),
    .u0_o      (u0),
    .v0_o      (v0)
  );

  // Coverage test on the current edge values
  always_comb begin
    sum_uv   = (UW+1)'(u_q) + (UW+1)'(v_q);
    area_x   = (UW+1)'(area_q);
    area_neg = area_q[UW-1];
    area_pos = !area_q[UW-1] && (area_q != '0);
    u_neg    = u_q[UW-1];
    v_neg    = v_q[UW-1];
    u_le0    = u_neg || (u_q == '0);
    v_le0    = v_neg || (v_q == '0);
    if (area_pos) begin
      cov = !u_neg && !v_neg && (sum_uv <= area_x);
    end else if (area_neg) begin
      cov = u_le0 && v_le0 && (sum_uv >= area_x);
    end else begin
      cov = 1'b0;
    end
  end

  assign end_x = (scan_x_q >= max_x);
  assign end_y = (scan_y_q >= max_y);

  // Result of a step; all zero without an active scan
  always_comb begin
    res = '0;
    if (scan_active_q) begin
      res.pixel_x    = tbr_pkg::PIX_W'(scan_x_q);
      res.pixel_y    = tbr_pkg::PIX_W'(scan_y_q);
      res.covered    = cov;
      res.in_scan    = 1'b1;
      res.last_pixel = end_x && end_y;
    end
  end

  // Vertex counter, scan position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q        <= '0;
      scan_active_q <= 1'b0;
      scan_x_q      <= '0;
      scan_y_q      <= '0;
    end else begin
      if (vtx_we) begin
        vcnt_q <= su_start ? '0 : vcnt_q + 1'b1;
      end
      if (su_status.done && !su_status.empty) begin
        scan_active_q <= 1'b1;
        scan_x_q      <= min_x;
        scan_y_q      <= min_y;
      end else if (step_xfer && scan_active_q) begin
        if (end_x) begin
          if (end_y) begin
            scan_active_q <= 1'b0;
          end else begin
            scan_x_q <= min_x;
            scan_y_q <= scan_y_q + 1'b1;
          end
        end else begin
          scan_x_q <= scan_x_q + 1'b1;
        end
      end
    end
  end

  // Edge values, stepped by the edge deltas
  always_ff @(posedge clk_i) begin
    if (su_status.done) begin
      area_q <= area0;
      u_q    <= u0;
      urow_q <= u0;
      v_q    <= v0;
      vrow_q <= v0;
    end else if (step_xfer && scan_active_q) begin
      if (end_x) begin
        u_q    <= urow_q - UW'(e2x);
        urow_q <= urow_q - UW'(e2x);
        v_q    <= vrow_q + UW'(e1x);
        vrow_q <= vrow_q + UW'(e1x);
      end else begin
        u_q <= u_q + UW'(e2y);
        v_q <= v_q - UW'(e1y);
      end
    end
  end

  // Output register with one skid entry
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= step_xfer;
      end
    end else if (step_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (step_xfer) begin
        out_q <= res;
      end
    end else if (step_xfer) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_q.pixel_x;
  assign pixel_y_o    = out_q.pixel_y;
  assign covered_o    = out_q.covered;
  assign in_scan_o    = out_q.in_scan;
  assign last_pixel_o = out_q.last_pixel;

endmodule

`default_nettype wire

// File: hw/rtl/tbr_checker.sv
`default_nettype none

// Port-level checks on the result channel
module tbr_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [tbr_pkg::PIX_W-1:0] pixel_x_o,
  input wire logic [tbr_pkg::PIX_W-1:0] pixel_y_o,
  input wire logic                     covered_o,
  input wire logic                     in_scan_o,
  input wire logic                     last_pixel_o
);

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_x_o) && $stable(pixel_y_o) &&
      $stable(covered_o) && $stable(in_scan_o) && $stable(last_pixel_o))
    else $error("result payload changed while stalled");

  // Coverage only on a visited box pixel
  a_cov_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && covered_o |-> in_scan_o)
    else $error("covered pixel outside a scan");

  // Last pixel only within a scan
  a_last_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> in_scan_o)
    else $error("last pixel outside a scan");

  // A step without a triangle returns zero pixel coordinates
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_scan_o |-> (pixel_x_o == '0) && (pixel_y_o == '0))
    else $error("idle step with non-zero position");

endmodule

bind triangle_bbox_edge_rasterizer tbr_checker u_tbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_x_o    (pixel_x_o),
  .pixel_y_o    (pixel_y_o),
  .covered_o    (covered_o),
  .in_scan_o    (in_scan_o),
  .last_pixel_o (last_pixel_o)
);

`default_nettype wire

// File: test/triangle_bbox_edge_rasterizer_tb.sv
module triangle_bbox_edge_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int END_LIMIT     = 5000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 120;
  localparam int MAX_REPORTS   = 40;
  localparam int TIMEOUT_NS    = 2_000_000;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_FRAME_HEIGHT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_FRAME_HEIGHT + 3'd2;

  // Tracks vertices, clamped box and scan position; holds expected pixels
  class pixel_scoreboard;
    logic signed [VP_POS_W-1:0] vp_x, vp_y;
    logic [VP_SIZE_W-1:0]       vp_w, vp_h;
    logic [FB_SIZE_W-1:0]       fb_w, fb_h;
    int   corner_x[3], corner_y[3];
    int   loaded;
    bit   scanning;
    int   box_x0, box_y0, box_x1, box_y1;
    int   cur_x, cur_y;
    res_t pending_pixels[$];
    int   errors;
    int   seen;

    function new();
      vp_x     = '0;
      vp_y     = '0;
      vp_w     = '0;
      vp_h     = '0;
      fb_w     = FB_SIZE_RESET;
      fb_h     = FB_SIZE_RESET;
      loaded   = 0;
      scanning = 1'b0;
      cur_x    = 0;
      cur_y    = 0;
      errors   = 0;
      seen     = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIEWPORT_X:   vp_x = data[VP_POS_W-1:0];
        CFG_VIEWPORT_Y:   vp_y = data[VP_POS_W-1:0];
        CFG_VIEWPORT_W:   vp_w = data[VP_SIZE_W-1:0];
        CFG_VIEWPORT_H:   vp_h = data[VP_SIZE_W-1:0];
        CFG_FRAME_WIDTH:  fb_w = data[FB_SIZE_W-1:0];
        CFG_FRAME_HEIGHT: fb_h = data[FB_SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Intersection of viewport and framebuffer; empty when lo > hi
    function void clip_window(output int lox, output int loy, output int hix, output int hiy);
      int fw, fh;
      fw  = (int'(fb_w) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(fb_w);
      fh  = (int'(fb_h) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(fb_h);
      lox = (vp_x > 0) ? int'(vp_x) : 0;
      loy = (vp_y > 0) ? int'(vp_y) : 0;
      hix = int'(vp_x) + int'(vp_w) - 1;
      hiy = int'(vp_y) + int'(vp_h) - 1;
      if (hix > fw - 1) hix = fw - 1;
      if (hiy > fh - 1) hiy = fh - 1;
    endfunction

    function int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Latch the clamped bounding box and start the row-order walk
    function void start_box();
      int lox, loy, hix, hiy;
      int mnx, mxx, mny, mxy;
      clip_window(lox, loy, hix, hiy);
      mnx = corner_x[0];
      mxx = mnx;
      mny = corner_y[0];
      mxy = mny;
      for (int i = 1; i < 3; i++) begin
        if (corner_x[i] < mnx) mnx = corner_x[i];
        if (corner_x[i] > mxx) mxx = corner_x[i];
        if (corner_y[i] < mny) mny = corner_y[i];
        if (corner_y[i] > mxy) mxy = corner_y[i];
      end
      if (lox > hix || loy > hiy) return;
      box_x0   = clamp(mnx, lox, hix);
      box_y0   = clamp(mny, loy, hiy);
      box_x1   = clamp(mxx, lox, hix);
      box_y1   = clamp(mxy, loy, hiy);
      cur_x    = box_x0;
      cur_y    = box_y0;
      scanning = 1'b1;
    endfunction

    // Edge-function test, inclusive edges, either winding
    function bit covers(int px, int py);
      longint ax, ay, bx, by, cx, cy, area, u, v;
      ax   = corner_x[0];
      ay   = corner_y[0];
      bx   = corner_x[1];
      by   = corner_y[1];
      cx   = corner_x[2];
      cy   = corner_y[2];
      area = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
      u    = (cx - ax) * (ay - py) - (ax - px) * (cy - ay);
      v    = (ax - px) * (by - ay) - (bx - ax) * (ay - py);
      if (area > 0) return u >= 0 && v >= 0 && u + v <= area;
      if (area < 0) return u <= 0 && v <= 0 && u + v >= area;
      return 1'b0;
    endfunction

    function void take_item(logic op, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      res_t px;
      px = '0;
      if (op == OP_VERTEX) begin
        // vertices arriving mid-scan are dropped
        if (!scanning) begin
          corner_x[loaded] = x;
          corner_y[loaded] = y;
          if (loaded == int'(VTX_LAST)) begin
            loaded = 0;
            start_box();
          end else begin
            loaded++;
          end
        end
        return;
      end
      if (scanning) begin
        px.pixel_x    = PIX_W'(cur_x);
        px.pixel_y    = PIX_W'(cur_y);
        px.covered    = covers(cur_x, cur_y);
        px.in_scan    = 1'b1;
        px.last_pixel = (cur_x >= box_x1) && (cur_y >= box_y1);
        if (cur_x >= box_x1) begin
          if (cur_y >= box_y1) begin
            scanning = 1'b0;
          end else begin
            cur_x = box_x0;
            cur_y++;
          end
        end else begin
          cur_x++;
        end
      end
      pending_pixels = {pending_pixels, px};
    endfunction

    task match_pixel(res_t got);
      res_t want;
      seen++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", seen));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report($sformatf("result %0d pixel_x %0d, want %0d", seen, got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report($sformatf("result %0d pixel_y %0d, want %0d", seen, got.pixel_y, want.pixel_y));
      if (got.covered !== want.covered)
        report($sformatf("result %0d covered %b, want %b", seen, got.covered, want.covered));
      if (got.in_scan !== want.in_scan)
        report($sformatf("result %0d in_scan %b, want %b", seen, got.in_scan, want.in_scan));
      if (got.last_pixel !== want.last_pixel)
        report($sformatf("result %0d last_pixel %b, want %b", seen, got.last_pixel,
                         want.last_pixel));
    endtask

    task close();
      if (pending_pixels.size() != 0)
        report($sformatf("%0d expected results never arrived", pending_pixels.size()));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  opcode     = OP_VERTEX;
  logic signed [CW-1:0]  vert_x     = '0;
  logic signed [CW-1:0]  vert_y     = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic                  covered;
  logic                  in_scan;
  logic                  last_pixel;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  bit              calm      = 1'b0;
  bit              hold_ask  = 1'b0;
  int              items_sent = 0;
  pixel_scoreboard sb;

  triangle_bbox_edge_rasterizer i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .vert_x_i     (vert_x),
    .vert_y_i     (vert_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .covered_o    (covered),
    .in_scan_o    (in_scan),
    .last_pixel_o (last_pixel),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Result side: random stalls, plus one long hold when asked
  initial begin : sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Every result transfer is checked against the oldest expected pixel
  always @(posedge clk) begin : monitor
    res_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.pixel_x    = pixel_x;
      got.pixel_y    = pixel_y;
      got.covered    = covered;
      got.in_scan    = in_scan;
      got.last_pixel = last_pixel;
      sb.match_pixel(got);
    end
  end

  task automatic send_item(logic op, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    // a vertex offered mid-scan is ignored by the block, so it is not counted
    if (!(op == OP_VERTEX && sb.scanning)) items_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    vert_x   <= x;
    vert_y   <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(op, x, y);
  endtask

  task automatic send_step();
    send_item(OP_STEP, CW'($urandom), CW'($urandom));
  endtask

  task automatic send_triangle(int ax, int ay, int bx, int by, int cx, int cy);
    send_item(OP_VERTEX, CW'(ax), CW'(ay));
    send_item(OP_VERTEX, CW'(bx), CW'(by));
    send_item(OP_VERTEX, CW'(cx), CW'(cy));
  endtask

  task automatic finish_scan();
    while (sb.scanning) send_step();
  endtask

  // Stop offering, wait for every expected pixel, then let setup settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Unused top data bit of the 13-bit registers is randomised
  task automatic set_config(int px, int py, int pw, int ph, int fw, int fh);
    cfg_write(CFG_VIEWPORT_X,   {1'($urandom), VP_POS_W'(px)});
    cfg_write(CFG_VIEWPORT_Y,   {1'($urandom), VP_POS_W'(py)});
    cfg_write(CFG_VIEWPORT_W,   VP_SIZE_W'(pw));
    cfg_write(CFG_VIEWPORT_H,   VP_SIZE_W'(ph));
    cfg_write(CFG_FRAME_WIDTH,  {1'($urandom), FB_SIZE_W'(fw)});
    cfg_write(CFG_FRAME_HEIGHT, {1'($urandom), FB_SIZE_W'(fh)});
  endtask

  // One axis of a random setting; the clipped range stays at most a dozen pixels
  task automatic pick_axis(output int pos, output int size, output int fb);
    int lim;
    case ($urandom_range(0, 2))
      0: begin
        // small viewport anywhere inside a framebuffer of any size
        fb   = $urandom_range(1, 8191);
        lim  = (fb > MAX_DIM_DEF) ? MAX_DIM_DEF : fb;
        pos  = int'($urandom_range(0, lim - 1)) - int'($urandom_range(0, 3));
        size = $urandom_range(0, 10);
      end
      1: begin
        // huge viewport, tiny (possibly zero) framebuffer
        fb   = $urandom_range(0, 11);
        pos  = -int'($urandom_range(0, 4096));
        size = $urandom_range(8192, 16383);
      end
      default: begin
        // viewport straddling the far framebuffer edge
        fb   = $urandom_range(1, 8191);
        lim  = (fb > MAX_DIM_DEF) ? MAX_DIM_DEF : fb;
        pos  = lim - int'($urandom_range(1, 10));
        size = $urandom_range(0, 16383);
      end
    endcase
  endtask

  function automatic logic signed [CW-1:0] near_coord(int lo, int hi);
    if (hi < lo || $urandom_range(0, 99) < 12) return CW'($urandom);
    return CW'(lo - 3 + int'($urandom_range(0, hi - lo + 6)));
  endfunction

  initial begin : stimulus
    int lx, ly, hx, hy, stop_at, waited;
    int px, py, pw, ph, fw, fh;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Out of reset the viewport is empty: steps see no scan, triangle discarded
    send_step();
    send_triangle(1, 1, 2, 2, 3, 1);
    send_step();
    drain();

    // Window x 2..4, y 1..2
    set_config(2, 1, 3, 2, 4096, 4096);
    // full-range corners, both windings
    send_triangle(-32768, -32768, -32768, 32767, 32767, 32767);
    finish_scan();
    send_triangle(32767, 32767, -32768, 32767, -32768, -32768);
    finish_scan();
    // collinear corners: zero area covers nothing
    send_triangle(0, 0, 3, 1, 6, 2);
    finish_scan();
    send_step();
    // vertex mid-scan is dropped; register write mid-scan keeps the latched box
    send_triangle(-1, -1, 6, -1, -1, 4);
    send_step();
    send_item(OP_VERTEX, '0, '0);
    send_step();
    drain();
    cfg_write(CFG_VIEWPORT_W, '0);
    finish_scan();
    send_step();
    drain();

    // Widest viewport, oversized framebuffer saturates; corners at both ends
    set_config(-4096, -4096, 16383, 8192, 8191, 4096);
    send_triangle(4090, 4093, 4095, 4095, 5000, 4094);
    finish_scan();
    send_triangle(-5, -3, 2, -7, 1, 2);
    finish_scan();
    drain();

    // Single-pixel window at the right edge, then a zero-width framebuffer
    set_config(4095, 0, 1, 1, 4096, 1);
    send_triangle(4095, 0, 4095, 5, 4100, 0);
    finish_scan();
    send_triangle(4095, 0, 4095, 0, 4095, 0);
    finish_scan();
    drain();
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '1);
    cfg_write(CFG_FRAME_WIDTH, '0);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_step();
    drain();

    // Back-pressure: the sink holds off while a 64-pixel box is stepped
    set_config(0, 0, 8, 8, 64, 64);
    send_triangle(0, 0, 7, 0, 0, 7);
    hold_ask = 1'b1;
    finish_scan();

    // Random phases, each with its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      pick_axis(px, pw, fw);
      pick_axis(py, ph, fh);
      set_config(px, py, pw, ph, fw, fh);
      calm    = (phase == 5) || (phase == 6);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if (sb.scanning) begin
          if ($urandom_range(0, 99) < 4) send_item(OP_VERTEX, CW'($urandom), CW'($urandom));
          else send_step();
        end else if ($urandom_range(0, 99) < 8) begin
          send_step();
        end else begin
          sb.clip_window(lx, ly, hx, hy);
          send_item(OP_VERTEX, near_coord(lx, hx), near_coord(ly, hy));
        end
      end
      finish_scan();
    end
    calm = 1'b0;

    // Wind down
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_pixels.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("triangle_bbox_edge_rasterizer_tb OK");
    end else begin
      $display("triangle_bbox_edge_rasterizer_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("triangle_bbox_edge_rasterizer_tb NOT OK");
    $finish;
  end

endmodule

// File: triangle_bbox_edge_rasterizer.f
hw/rtl/tbr_pkg.sv
hw/rtl/tbr_setup.sv
hw/rtl/triangle_bbox_edge_rasterizer.sv
hw/rtl/tbr_checker.sv
test/triangle_bbox_edge_rasterizer_tb.sv
